[hw/rtl/dxtd_pkg.sv]
// ----------------------------------------------------------------------------
// DXT block decoder package
// Shared widths, register indexes and the block descriptor that travels from
// the front end through the queue to the texel emitter.
// ----------------------------------------------------------------------------
package dxtd_pkg;

  // Stream word widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 56;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // Largest image side in texels; larger register values are clamped to it
  localparam logic [CFG_DATA_W-1:0] MAX_SIDE = 13'd4096;

  // Default depth of the block queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Block descriptor: resolved palette plus everything the emitter needs
  typedef struct packed {
    logic [3:0][7:0] pal_red;
    logic [3:0][7:0] pal_green;
    logic [3:0][7:0] pal_blue;
    logic [31:0]     sel;
    logic [63:0]     alpha_nib;
    logic            dxt3;
    logic            three;
    logic [11:0]     base_x;
    logic [11:0]     base_y;
    logic [2:0]      x_cnt;
    logic [2:0]      y_cnt;
  } desc_t;

endpackage

[hw/rtl/dxtd_front.sv]
// ----------------------------------------------------------------------------
// DXT block decoder front end
// Holds the configuration registers and the block position counters, builds
// the four-entry palette of each accepted block and pushes a descriptor.
// ----------------------------------------------------------------------------
module dxtd_front
  import dxtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output desc_t                 q_desc
);

  // Reciprocal of three in 11 fractional bits, exact for values below 768
  localparam logic [9:0] RECIP3 = 10'd683;

  logic                  format_mode_r;
  logic [CFG_DATA_W-1:0] image_width_r;
  logic [CFG_DATA_W-1:0] image_height_r;
  logic [9:0]            block_column_r;
  logic [9:0]            block_row_r;
  logic [9:0]            block_column_nxt;
  logic [9:0]            block_row_nxt;

  logic [15:0]           ep0;
  logic [15:0]           ep1;
  logic [CFG_DATA_W-1:0] w_eff;
  logic [CFG_DATA_W-1:0] h_eff;
  logic [10:0]           cols;
  logic [10:0]           rows;
  logic [10:0]           col_inc;
  logic [10:0]           row_inc;
  logic [11:0]           base_x;
  logic [11:0]           base_y;
  logic [2:0]            x_cnt;
  logic [2:0]            y_cnt;
  logic                  dxt3;
  logic                  three;
  logic [2:0][7:0]       c0;
  logic [2:0][7:0]       c1;
  logic [2:0][7:0]       mid_a;
  logic [2:0][7:0]       mid_b;
  logic                  accept;

  // Divide a small sum by three through the reciprocal product
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] prod;
    prod = v * RECIP3;
    return prod[18:11];
  endfunction

  // Clamp a side register into 1..MAX_SIDE
  function automatic logic [CFG_DATA_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_DATA_W'(1);
    else if (v > MAX_SIDE) r = MAX_SIDE;
    return r;
  endfunction

  // Number of texels of the block along one side, 0 when outside the image
  function automatic logic [2:0] side_cnt(input logic [CFG_DATA_W-1:0] lim,
                                          input logic [11:0] base);
    logic [CFG_DATA_W-1:0] rem;
    logic [2:0]            r;
    rem = lim - {1'b0, base};
    if ({1'b0, base} >= lim) r = 3'd0;
    else if (rem >= CFG_DATA_W'(4)) r = 3'd4;
    else r = rem[2:0];
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r  <= 1'b0;
      image_width_r  <= CFG_DATA_W'(4);
      image_height_r <= CFG_DATA_W'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FORMAT_MODE:  format_mode_r  <= cfg_data[0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image geometry and block extent
  always_comb begin
    w_eff  = clamp_side(image_width_r);
    h_eff  = clamp_side(image_height_r);
    cols   = 11'((w_eff + CFG_DATA_W'(3)) >> 2);
    rows   = 11'((h_eff + CFG_DATA_W'(3)) >> 2);
    base_x = {block_column_r, 2'b00};
    base_y = {block_row_r, 2'b00};
    x_cnt  = side_cnt(w_eff, base_x);
    y_cnt  = side_cnt(h_eff, base_y);
  end

  // Block counters advance per accepted block and wrap at the image end
  always_comb begin
    col_inc          = {1'b0, block_column_r} + 11'd1;
    row_inc          = {1'b0, block_row_r} + 11'd1;
    block_column_nxt = col_inc[9:0];
    block_row_nxt    = block_row_r;
    if (col_inc >= cols) begin
      block_column_nxt = '0;
      block_row_nxt    = (row_inc >= rows) ? '0 : row_inc[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_column_r <= '0;
      block_row_r    <= '0;
    end else if (accept) begin
      block_column_r <= block_column_nxt;
      block_row_r    <= block_row_nxt;
    end
  end

  // Endpoint expansion and palette interpolation
  always_comb begin
    ep0   = in_tdata[15:0];
    ep1   = in_tdata[31:16];
    dxt3  = format_mode_r;
    three = !format_mode_r && (ep0 <= ep1);
    c0[0] = {ep0[15:11], 3'b000};
    c0[1] = {ep0[10:5], 2'b00};
    c0[2] = {ep0[4:0], 3'b000};
    c1[0] = {ep1[15:11], 3'b000};
    c1[1] = {ep1[10:5], 2'b00};
    c1[2] = {ep1[4:0], 3'b000};
    for (int k = 0; k < 3; k++) begin
      if (three) begin
        mid_a[k] = 8'(({1'b0, c0[k]} + {1'b0, c1[k]}) >> 1);
        mid_b[k] = '0;
      end else begin
        mid_a[k] = div3({1'b0, c0[k], 1'b0} + {2'b00, c1[k]});
        mid_b[k] = div3({2'b00, c0[k]} + {1'b0, c1[k], 1'b0});
      end
    end
  end

  // Descriptor for the emitter; blocks wholly outside the image are dropped
  always_comb begin
    q_desc.pal_red   = {mid_b[0], mid_a[0], c1[0], c0[0]};
    q_desc.pal_green = {mid_b[1], mid_a[1], c1[1], c0[1]};
    q_desc.pal_blue  = {mid_b[2], mid_a[2], c1[2], c0[2]};
    q_desc.sel       = in_tdata[63:32];
    q_desc.alpha_nib = in_tdata[127:64];
    q_desc.dxt3      = dxt3;
    q_desc.three     = three;
    q_desc.base_x    = base_x;
    q_desc.base_y    = base_y;
    q_desc.x_cnt     = x_cnt;
    q_desc.y_cnt     = y_cnt;
    q_push           = accept && (x_cnt != 3'd0) && (y_cnt != 3'd0);
  end

endmodule

[hw/rtl/dxtd_queue.sv]
// ----------------------------------------------------------------------------
// DXT block decoder descriptor queue
// Small register FIFO that decouples block intake from texel emission.
// ----------------------------------------------------------------------------
module dxtd_queue
  import dxtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  // Queue integrity
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("descriptor pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("descriptor popped from an empty queue");
  a_nonempty_desc: assert property (@(posedge clk) disable iff (!rst_n)
      push |-> (push_desc.x_cnt != 3'd0) && (push_desc.y_cnt != 3'd0))
    else $error("queued block covers no texel");

endmodule

[hw/rtl/dxtd_back.sv]
// ----------------------------------------------------------------------------
// DXT block decoder texel emitter
// Walks the in-image texels of the head block in raster order and emits one
// decoded RGBA texel per cycle unless stalled, via a registered output word.
// ----------------------------------------------------------------------------
module dxtd_back
  import dxtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  desc_t                 q_head,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [1:0]            lx_r;
  logic [1:0]            ly_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tlast_r;

  logic                  load;
  logic                  last_x;
  logic                  last_y;
  logic [3:0]            t;
  logic [1:0]            idx;
  logic [7:0]            alpha;
  logic [3:0]            nib;

  assign load   = q_valid && (!out_tvalid_r || out_tready);
  assign last_x = ({1'b0, lx_r} == (q_head.x_cnt - 3'd1));
  assign last_y = ({1'b0, ly_r} == (q_head.y_cnt - 3'd1));
  assign q_pop  = load && last_x && last_y;

  // Texel lookup for the current cursor position
  always_comb begin
    t   = {ly_r, lx_r};
    idx = q_head.sel[{t, 1'b0} +: 2];
    nib = q_head.alpha_nib[{t, 2'b00} +: 4];
    if (q_head.dxt3) alpha = {nib, 4'b0000};
    else alpha = (q_head.three && (idx == 2'd3)) ? 8'd0 : 8'd255;
  end

  // Cursor inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= '0;
      ly_r <= '0;
    end else if (load) begin
      if (last_x) begin
        lx_r <= '0;
        ly_r <= last_y ? 2'd0 : ly_r + 2'd1;
      end else begin
        lx_r <= lx_r + 2'd1;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {q_head.base_y + {10'd0, ly_r},
                      q_head.base_x + {10'd0, lx_r},
                      alpha,
                      q_head.pal_blue[idx],
                      q_head.pal_green[idx],
                      q_head.pal_red[idx]};
      out_tlast_r <= last_x && last_y;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Cursor stays inside the head block and restarts after each block
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
      q_valid |-> ({1'b0, lx_r} < q_head.x_cnt) && ({1'b0, ly_r} < q_head.y_cnt))
    else $error("texel cursor outside the block extent");
  a_cursor_restart: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |=> (lx_r == 2'd0) && (ly_r == 2'd0))
    else $error("texel cursor not restarted after block end");

endmodule

[hw/rtl/dxt_block_texture_decoder_unit.sv]
// ----------------------------------------------------------------------------
// DXT1 / DXT3 block texture decoder
// Takes one compressed 4x4 block per word in raster block order and emits the
// decoded RGBA texels that fall inside the image, one texel per word.
//
//   Channel  Dir  Handshake            Payload
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in   in_tvalid/in_tready  in_tdata (128 bits)
//   out      out  out_tvalid/out_tready out_tdata (56 bits), out_tlast
//
// The texel emitter performs one texel lookup per cycle while the output is
// not stalled, covering each in-image texel of the block.
// The front end accepts a block whenever the descriptor queue has room, so
// the next block enters while the current one is still being emitted.
// A block's first texel passes the descriptor queue, then the output register.
// Reset is synchronous, active low; it restores the default registers and
// returns the block position to the image origin.
// A stalled output holds its word; the queue then fills and in_tready drops.
// ----------------------------------------------------------------------------
module dxt_block_texture_decoder_unit
  import dxtd_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Compressed blocks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // endpoint_zero[15:0], endpoint_one[31:16], texel_selectors[63:32],
  // alpha_nibbles[127:64]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Decoded texels
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], pos_x[43:32],
  // pos_y[55:44]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // block_done
  output logic                  out_tlast
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  desc_t q_push_desc;
  desc_t q_head;

  // Block intake and palette construction
  dxtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_push_desc)
  );

  // Descriptor queue
  dxtd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (q_head)
  );

  // Texel emission
  dxtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
